@@ sv/tls_pkg.sv @@
// shared types, codes and field widths of the text line store engine
`default_nettype none

package tls_pkg;

   localparam int OP_W      = 3;
   localparam int LI_W      = 8;
   localparam int COL_W     = 6;
   localparam int CH_W      = 8;
   localparam int ST_W      = 2;
   localparam int LEN_OUT_W = 7;
   localparam int CNT_OUT_W = 9;

   localparam logic [CH_W-1:0] FILL_RESET = 8'd32;

   localparam logic [OP_W-1:0] OP_INS_LINE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_LINE = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_CHAR = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_CHAR = 3'd3;
   localparam logic [OP_W-1:0] OP_WR_CHAR  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLR_LINE = 3'd5;
   localparam logic [OP_W-1:0] OP_RD_CHAR  = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   // one datapath step per cycle
   typedef enum logic [4:0] {
      C_NOP, C_LOAD, C_SET_RANGE, C_SET_FULL, C_SCAN,
      C_UP_INIT, C_UP_RD, C_UP_WR, C_INS_LINE, C_BLANK,
      C_TBL_RD, C_TBL_GET, C_DN_INIT, C_DN_RD, C_DN_WR, C_DEL_LINE,
      C_CR_INIT, C_CR_RD, C_CR_WR, C_CL_INIT, C_CL_RD, C_CL_WR,
      C_PUT_CH, C_PUT_FILL, C_LEN_SET, C_CH_RD, C_CH_GET, C_FIN_RD, C_FIN
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic present;
      logic ins_range;
      logic cnt_full;
      logic slot_free;
      logic up_more;
      logic dn_more;
      logic blank_last;
      logic col_gt_len;
      logic len_full;
      logic col_ge_len;
      logic col_ge_lc;
      logic cr_more;
      logic cl_more;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ sv/tls_if.sv @@
// request, response and register write channels
`default_nettype none

interface tls_req_if;
   import tls_pkg::*;
   logic valid;
   logic ready;
   logic [OP_W-1:0]  opcode;
   logic [LI_W-1:0]  line_index;
   logic [COL_W-1:0] column;
   logic [CH_W-1:0]  char_in;
   modport source (output valid, opcode, line_index, column, char_in, input ready);
   modport sink   (input valid, opcode, line_index, column, char_in, output ready);
endinterface

interface tls_rsp_if;
   import tls_pkg::*;
   logic valid;
   logic ready;
   logic [ST_W-1:0]      status;
   logic [CH_W-1:0]      char_out;
   logic [LEN_OUT_W-1:0] line_length;
   logic [CNT_OUT_W-1:0] line_count;
   modport source (output valid, status, char_out, line_length, line_count, input ready);
   modport sink   (input valid, status, char_out, line_length, line_count, output ready);
endinterface

interface tls_csr_if;
   import tls_pkg::*;
   logic valid;
   logic ready;
   logic [CH_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/tls_ram.sv @@
// generic memory, one write port and one registered read port
`default_nettype none

module tls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

@@ sv/tls_ctrl.sv @@
// command sequencer of the text line store engine
`default_nettype none

module tls_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tls_pkg::dp_stat_type st,
   output tls_pkg::dp_cmd_type       cmd
);
   import tls_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_SCAN, S_UPI, S_UPCHK, S_UPWR, S_BLANK, S_GET, S_EXEC,
      S_DNCHK, S_DNWR, S_CRCHK, S_CRWR, S_CLCHK, S_CLWR, S_LEN, S_CHGET,
      S_FIN_RD, S_FIN
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = C_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = C_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (st.op == OP_INS_LINE) begin
               if (st.ins_range) begin
                  cmd = C_SET_RANGE;
                  state_in = S_FIN_RD;
               end else if (st.cnt_full) begin
                  cmd = C_SET_FULL;
                  state_in = S_FIN_RD;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (st.op inside {[OP_DEL_LINE:OP_RD_CHAR]}) begin
               if (!st.present) begin
                  cmd = C_SET_RANGE;
                  state_in = S_FIN_RD;
               end else begin
                  cmd = C_TBL_RD;
                  state_in = S_GET;
               end
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_SCAN: begin
            cmd = C_SCAN;
            if (st.slot_free) begin
               state_in = S_UPI;
            end
         end
         S_UPI: begin
            cmd = C_UP_INIT;
            state_in = S_UPCHK;
         end
         S_UPCHK: begin
            if (st.up_more) begin
               cmd = C_UP_RD;
               state_in = S_UPWR;
            end else begin
               cmd = C_INS_LINE;
               state_in = S_BLANK;
            end
         end
         S_UPWR: begin
            cmd = C_UP_WR;
            state_in = S_UPCHK;
         end
         S_BLANK: begin
            cmd = C_BLANK;
            if (st.blank_last) begin
               state_in = S_FIN_RD;
            end
         end
         S_GET: begin
            cmd = C_TBL_GET;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN_RD;
            case (st.op)
               OP_DEL_LINE: begin
                  cmd = C_DN_INIT;
                  state_in = S_DNCHK;
               end
               OP_INS_CHAR: begin
                  if (st.col_gt_len) begin
                     cmd = C_SET_RANGE;
                  end else if (st.len_full) begin
                     cmd = C_SET_FULL;
                  end else begin
                     cmd = C_CR_INIT;
                     state_in = S_CRCHK;
                  end
               end
               OP_DEL_CHAR: begin
                  if (st.col_ge_len) begin
                     cmd = C_SET_RANGE;
                  end else begin
                     cmd = C_CL_INIT;
                     state_in = S_CLCHK;
                  end
               end
               OP_WR_CHAR: begin
                  if (st.col_ge_lc) begin
                     cmd = C_SET_RANGE;
                  end else begin
                     cmd = C_PUT_CH;
                     state_in = S_LEN;
                  end
               end
               OP_CLR_LINE: begin
                  cmd = C_LEN_SET;
                  state_in = S_BLANK;
               end
               OP_RD_CHAR: begin
                  if (st.col_ge_lc) begin
                     cmd = C_SET_RANGE;
                  end else begin
                     cmd = C_CH_RD;
                     state_in = S_CHGET;
                  end
               end
               default: ;
            endcase
         end
         S_DNCHK: begin
            if (st.dn_more) begin
               cmd = C_DN_RD;
               state_in = S_DNWR;
            end else begin
               cmd = C_DEL_LINE;
               state_in = S_FIN_RD;
            end
         end
         S_DNWR: begin
            cmd = C_DN_WR;
            state_in = S_DNCHK;
         end
         S_CRCHK: begin
            if (st.cr_more) begin
               cmd = C_CR_RD;
               state_in = S_CRWR;
            end else begin
               cmd = C_PUT_CH;
               state_in = S_LEN;
            end
         end
         S_CRWR: begin
            cmd = C_CR_WR;
            state_in = S_CRCHK;
         end
         S_CLCHK: begin
            if (st.cl_more) begin
               cmd = C_CL_RD;
               state_in = S_CLWR;
            end else begin
               cmd = C_PUT_FILL;
               state_in = S_LEN;
            end
         end
         S_CLWR: begin
            cmd = C_CL_WR;
            state_in = S_CLCHK;
         end
         S_LEN: begin
            cmd = C_LEN_SET;
            state_in = S_FIN_RD;
         end
         S_CHGET: begin
            cmd = C_CH_GET;
            state_in = S_FIN_RD;
         end
         S_FIN_RD: begin
            cmd = C_FIN_RD;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (st.out_free) begin
               cmd = C_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

`default_nettype wire

@@ sv/tls_dp.sv @@
// line table, free map, character store and result register
`default_nettype none

module tls_dp #(
   parameter int MAX_LINES  = 256,
   parameter int LINE_CHARS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tls_pkg::dp_cmd_type              cmd,
   output tls_pkg::dp_stat_type                  st,
   input  wire logic [tls_pkg::OP_W-1:0]         req_opcode,
   input  wire logic [tls_pkg::LI_W-1:0]         req_line_index,
   input  wire logic [tls_pkg::COL_W-1:0]        req_column,
   input  wire logic [tls_pkg::CH_W-1:0]         req_char_in,
   input  wire logic                             csr_valid,
   input  wire logic [tls_pkg::CH_W-1:0]         csr_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [tls_pkg::ST_W-1:0]         rsp_status,
   output logic      [tls_pkg::CH_W-1:0]         rsp_char_out,
   output logic      [tls_pkg::LEN_OUT_W-1:0]    rsp_line_length,
   output logic      [tls_pkg::CNT_OUT_W-1:0]    rsp_line_count
);
   import tls_pkg::*;

   localparam int SLOT_W = $clog2(MAX_LINES);
   localparam int CNT_W  = $clog2(MAX_LINES + 1);
   localparam int LEN_W  = $clog2(LINE_CHARS + 1);
   localparam int TBL_W  = SLOT_W + LEN_W;
   localparam int CDEPTH = MAX_LINES * LINE_CHARS;
   localparam int CA_W   = $clog2(CDEPTH);
   localparam int CW     = (CNT_W > LI_W) ? CNT_W : LI_W;
   localparam int CLW    = ((LEN_W > COL_W) ? LEN_W : COL_W) + 1;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [LI_W-1:0]   li_ff, li_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [CH_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]  cptr_ff, cptr_in;
   logic [SLOT_W-1:0] sptr_ff, sptr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CA_W-1:0]   base_ff, base_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ST_W-1:0]   stat_ff, stat_in;
   logic [CH_W-1:0]   cout_ff, cout_in;
   logic [MAX_LINES-1:0] used_ff, used_in;
   logic              rv_ff, rv_in;
   logic [ST_W-1:0]      rst_ff, rst_in;
   logic [CH_W-1:0]      rch_ff, rch_in;
   logic [LEN_OUT_W-1:0] rlen_ff, rlen_in;
   logic [CNT_OUT_W-1:0] rcnt_ff, rcnt_in;

   logic              t_we;
   logic [SLOT_W-1:0] t_waddr, t_raddr;
   logic [TBL_W-1:0]  t_wdata, t_rdata;
   logic              c_we;
   logic [CA_W-1:0]   c_waddr, c_raddr;
   logic [CH_W-1:0]   c_wdata, c_rdata;
   logic [LEN_W-1:0]  new_len;
   logic [LEN_W-1:0]  rd_len;
   logic              present;

   tls_ram #(.WIDTH(TBL_W), .DEPTH(MAX_LINES)) u_tbl (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   tls_ram #(.WIDTH(CH_W), .DEPTH(CDEPTH)) u_chars (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );

   assign rd_len  = t_rdata[LEN_W-1:0];
   assign present = CW'(li_ff) < CW'(cnt_ff);

   always_comb begin
      st.op         = op_ff;
      st.present    = present;
      st.ins_range  = (CW'(li_ff) > CW'(cnt_ff)) || (CW'(li_ff) >= CW'(MAX_LINES));
      st.cnt_full   = cnt_ff >= CNT_W'(MAX_LINES);
      st.slot_free  = !used_ff[sptr_ff];
      st.up_more    = CW'(ptr_ff) > CW'(li_ff);
      st.dn_more    = (CW'(ptr_ff) + CW'(1)) < CW'(cnt_ff);
      st.blank_last = cptr_ff == LEN_W'(LINE_CHARS - 1);
      st.col_gt_len = CLW'(col_ff) > CLW'(len_ff);
      st.len_full   = len_ff >= LEN_W'(LINE_CHARS);
      st.col_ge_len = CLW'(col_ff) >= CLW'(len_ff);
      st.col_ge_lc  = CLW'(col_ff) >= CLW'(LINE_CHARS);
      st.cr_more    = CLW'(cptr_ff) > CLW'(col_ff);
      st.cl_more    = (CLW'(cptr_ff) + CLW'(1)) < CLW'(len_ff);
      st.out_free   = !rv_ff || rsp_ready;
   end

   // length of the line after a character edit or clear
   always_comb begin
      case (op_ff)
         OP_INS_CHAR: new_len = len_ff + LEN_W'(1);
         OP_DEL_CHAR: new_len = len_ff - LEN_W'(1);
         OP_WR_CHAR: begin
            if (CLW'(len_ff) < CLW'(col_ff) + CLW'(1)) begin
               new_len = LEN_W'(col_ff) + LEN_W'(1);
            end else begin
               new_len = len_ff;
            end
         end
         OP_CLR_LINE: new_len = '0;
         default:     new_len = len_ff;
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      li_in   = li_ff;
      col_in  = col_ff;
      ch_in   = ch_ff;
      fill_in = fill_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      cptr_in = cptr_ff;
      sptr_in = sptr_ff;
      slot_in = slot_ff;
      base_in = base_ff;
      len_in  = len_ff;
      stat_in = stat_ff;
      cout_in = cout_ff;
      used_in = used_ff;
      rv_in   = rv_ff;
      rst_in  = rst_ff;
      rch_in  = rch_ff;
      rlen_in = rlen_ff;
      rcnt_in = rcnt_ff;
      t_we    = 1'b0;
      t_waddr = SLOT_W'(li_ff);
      t_wdata = {slot_ff, len_ff};
      t_raddr = SLOT_W'(li_ff);
      c_we    = 1'b0;
      c_waddr = base_ff + CA_W'(cptr_ff);
      c_wdata = fill_ff;
      c_raddr = base_ff + CA_W'(cptr_ff);

      if (csr_valid) begin
         fill_in = csr_data;
      end
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (cmd)
         C_LOAD: begin
            op_in   = req_opcode;
            li_in   = req_line_index;
            col_in  = req_column;
            ch_in   = req_char_in;
            stat_in = ST_OK;
            cout_in = '0;
            sptr_in = '0;
         end
         C_SET_RANGE: stat_in = ST_RANGE;
         C_SET_FULL:  stat_in = ST_FULL;
         C_SCAN: begin
            if (!used_ff[sptr_ff]) begin
               slot_in = sptr_ff;
               base_in = CA_W'(CA_W'(sptr_ff) * CA_W'(LINE_CHARS));
            end else begin
               sptr_in = sptr_ff + SLOT_W'(1);
            end
         end
         C_UP_INIT: ptr_in = cnt_ff;
         C_UP_RD:   t_raddr = SLOT_W'(ptr_ff - CNT_W'(1));
         C_UP_WR: begin
            t_we    = 1'b1;
            t_waddr = SLOT_W'(ptr_ff);
            t_wdata = t_rdata;
            ptr_in  = ptr_ff - CNT_W'(1);
         end
         C_INS_LINE: begin
            t_we             = 1'b1;
            t_wdata          = {slot_ff, LEN_W'(0)};
            used_in[slot_ff] = 1'b1;
            cnt_in           = cnt_ff + CNT_W'(1);
            cptr_in          = '0;
         end
         C_BLANK: begin
            c_we    = 1'b1;
            cptr_in = cptr_ff + LEN_W'(1);
         end
         C_TBL_GET: begin
            slot_in = t_rdata[TBL_W-1 -: SLOT_W];
            len_in  = rd_len;
            base_in = CA_W'(CA_W'(t_rdata[TBL_W-1 -: SLOT_W]) * CA_W'(LINE_CHARS));
         end
         C_DN_INIT: ptr_in = CNT_W'(li_ff);
         C_DN_RD:   t_raddr = SLOT_W'(ptr_ff + CNT_W'(1));
         C_DN_WR: begin
            t_we    = 1'b1;
            t_waddr = SLOT_W'(ptr_ff);
            t_wdata = t_rdata;
            ptr_in  = ptr_ff + CNT_W'(1);
         end
         C_DEL_LINE: begin
            used_in[slot_ff] = 1'b0;
            cnt_in           = cnt_ff - CNT_W'(1);
         end
         C_CR_INIT: cptr_in = len_ff;
         C_CR_RD:   c_raddr = base_ff + CA_W'(cptr_ff) - CA_W'(1);
         C_CR_WR: begin
            c_we    = 1'b1;
            c_wdata = c_rdata;
            cptr_in = cptr_ff - LEN_W'(1);
         end
         C_CL_INIT: cptr_in = LEN_W'(col_ff);
         C_CL_RD:   c_raddr = base_ff + CA_W'(cptr_ff) + CA_W'(1);
         C_CL_WR: begin
            c_we    = 1'b1;
            c_wdata = c_rdata;
            cptr_in = cptr_ff + LEN_W'(1);
         end
         C_PUT_CH: begin
            c_we    = 1'b1;
            c_waddr = base_ff + CA_W'(col_ff);
            c_wdata = ch_ff;
         end
         C_PUT_FILL: begin
            c_we    = 1'b1;
            c_waddr = base_ff + CA_W'(len_ff) - CA_W'(1);
         end
         C_LEN_SET: begin
            t_we    = 1'b1;
            t_wdata = {slot_ff, new_len};
            cptr_in = '0;
         end
         C_CH_RD:  c_raddr = base_ff + CA_W'(col_ff);
         C_CH_GET: cout_in = c_rdata;
         C_FIN: begin
            rv_in   = 1'b1;
            rst_in  = stat_ff;
            rch_in  = cout_ff;
            rlen_in = present ? LEN_OUT_W'(rd_len) : '0;
            rcnt_in = CNT_OUT_W'(cnt_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_RESET;
         cnt_ff  <= '0;
         used_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
         used_ff <= used_in;
         rv_ff   <= rv_in;
      end
      op_ff   <= op_in;
      li_ff   <= li_in;
      col_ff  <= col_in;
      ch_ff   <= ch_in;
      ptr_ff  <= ptr_in;
      cptr_ff <= cptr_in;
      sptr_ff <= sptr_in;
      slot_ff <= slot_in;
      base_ff <= base_in;
      len_ff  <= len_in;
      stat_ff <= stat_in;
      cout_ff <= cout_in;
      rst_ff  <= rst_in;
      rch_ff  <= rch_in;
      rlen_ff <= rlen_in;
      rcnt_ff <= rcnt_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rst_ff;
   assign rsp_char_out    = rch_ff;
   assign rsp_line_length = rlen_ff;
   assign rsp_line_count  = rcnt_ff;

   // free map and line count move together
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(cnt_ff))
      else $error("free map disagrees with line count");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_INS_LINE) |-> !used_ff[slot_ff])
      else $error("new line given a slot in use");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_FIN) |-> (!rv_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= MAX_LINES)
      else $error("line count above capacity");
endmodule

`default_nettype wire

@@ sv/text_line_store_engine.sv @@
// top level of the text line store engine
// One command per request, one response per command, one command in flight at a time;
// a finished response waits in an output register while the next request is taken.
// Some commands also sweep: line insert scans the slots for the lowest free one, moves
// the later lines up in the table and blanks the new slot; line delete moves the later
// lines down; character insert or delete moves the characters from the column on; clear
// line blanks the whole line. The line table and the character store each have one
// read and one write port with a registered read. Both stores need no clearing after
// reset. The user must write fill_char only while no command is in flight; the block
// itself does not enforce this. A written fill_char takes effect on later blanking.
`default_nettype none

module text_line_store_engine #(
   parameter int MAX_LINES  = 256,
   parameter int LINE_CHARS = 64
) (
   input wire logic clock,
   input wire logic reset,
   tls_req_if.sink   req_if,
   tls_rsp_if.source rsp_if,
   tls_csr_if.sink   csr_if
);
   import tls_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type st;

   assign csr_if.ready = 1'b1;

   tls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .st        (st),
      .cmd       (cmd)
   );

   tls_dp #(.MAX_LINES(MAX_LINES), .LINE_CHARS(LINE_CHARS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_opcode      (req_if.opcode),
      .req_line_index  (req_if.line_index),
      .req_column      (req_if.column),
      .req_char_in     (req_if.char_in),
      .csr_valid       (csr_if.valid),
      .csr_data        (csr_if.data),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_status      (rsp_if.status),
      .rsp_char_out    (rsp_if.char_out),
      .rsp_line_length (rsp_if.line_length),
      .rsp_line_count  (rsp_if.line_count)
   );
endmodule

`default_nettype wire
